### src/qhs_pkg.sv
// Types and constants shared by the quantized hard sigmoid block.
package qhs_pkg;

   // Field widths
   localparam int SAMPLE_W   = 8;
   localparam int SCALE_W    = 23;
   localparam int CSR_DATA_W = SCALE_W;

   // Fixed-point constants (Q15); the bias is 3.0, half the clamp range
   localparam int HALF_RANGE_Q15 = 98304;
   localparam int SIX_Q15        = 196608;
   localparam int Q15_SHIFT      = 15;

   // Divide by six: q = (y * RECIP_SIX) >> RECIP_SHIFT, exact for y < 2^19
   localparam int CLAMP_W     = 18;
   localparam int RECIP_SIX   = 174763;
   localparam int RECIP_SHIFT = 20;
   localparam int SIXTH_W     = 16;

   // Requantising divide: only eight quotient bits matter, anything larger saturates
   localparam int QUO_BITS   = 8;
   localparam int DIVIDEND_W = SIXTH_W + Q15_SHIFT;

   localparam int ACT_MAX = 127;
   localparam int ACT_MIN = -128;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Register reset values
   localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST = '0;
   localparam logic [SCALE_W-1:0]  IN_SCALE_RST    = SCALE_W'(32768);
   localparam logic [SCALE_W-1:0]  OUT_SCALE_RST   = SCALE_W'(32768);

   typedef enum logic [1:0] {
      CSR_ZERO_OFFSET = 2'd0,
      CSR_IN_SCALE    = 2'd1,
      CSR_OUT_SCALE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] activation;
      logic                       last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] zero_offset;
      logic [SCALE_W-1:0]         in_scale;
      logic [SCALE_W-1:0]         out_scale;
   } cfg_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic [DIVIDEND_W-1:0] dividend;
      logic                  sat;
      logic                  last;
   } qent_type;

endpackage

### src/qhs_front.sv
// Front end: dequantise, offset, clamp, divide by six, classify saturation.
module qhs_front import qhs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     push,
   output qent_type push_data,
   input  logic     queue_full
);

   logic                      advance;
   logic signed [SAMPLE_W:0]  diff_in;
   logic signed [32:0]        prod_full;
   logic signed [31:0]        prod_in;
   logic [32:0]               sum_in;
   logic [CLAMP_W-1:0]        clamp_in;
   logic [35:0]               scaled_in;
   logic [SIXTH_W-1:0]        sixth_in;
   logic [DIVIDEND_W-1:0]     dividend_in;
   logic [DIVIDEND_W-1:0]     limit_in;
   qent_type                  entry_in;

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [31:0]        s1_prod_ff;
   logic                      s1_last_ff, s2_last_ff, s3_last_ff;
   logic [CLAMP_W-1:0]        s2_clamp_ff;
   logic [SIXTH_W-1:0]        s3_sixth_ff;
   qent_type                  s4_entry_ff;

   assign advance   = !(s4_valid_ff && queue_full);
   assign req_stall = !advance;
   assign push      = s4_valid_ff && !queue_full;
   assign push_data = s4_entry_ff;

   // stage 1: (sample - zero point) * input scale
   assign diff_in   = $signed({req_payload.sample[SAMPLE_W-1], req_payload.sample})
                    - $signed({cfg.zero_offset[SAMPLE_W-1], cfg.zero_offset});
   assign prod_full = diff_in * $signed({1'b0, cfg.in_scale});
   assign prod_in   = prod_full[31:0];

   // stage 2: add 3.0 and clamp to [0, 6.0]
   assign sum_in = {s1_prod_ff[31], s1_prod_ff} + 33'(HALF_RANGE_Q15);
   always_comb begin
      if (sum_in[32]) begin
         clamp_in = '0;
      end else if (sum_in > 33'(SIX_Q15)) begin
         clamp_in = CLAMP_W'(SIX_Q15);
      end else begin
         clamp_in = sum_in[CLAMP_W-1:0];
      end
   end

   // stage 3: divide by six via reciprocal
   assign scaled_in = 36'(s2_clamp_ff) * 36'(RECIP_SIX);
   assign sixth_in  = scaled_in[RECIP_SHIFT +: SIXTH_W];

   // stage 4: shift to Q15 dividend, flag quotients of 256 and up
   assign dividend_in = {s3_sixth_ff, {Q15_SHIFT{1'b0}}};
   assign limit_in    = {cfg.out_scale, {QUO_BITS{1'b0}}};
   assign entry_in    = '{dividend: dividend_in,
                          sat:      (dividend_in >= limit_in),
                          last:     s3_last_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= prod_in;
         s1_last_ff  <= req_payload.last_in;
         s2_clamp_ff <= clamp_in;
         s2_last_ff  <= s1_last_ff;
         s3_sixth_ff <= sixth_in;
         s3_last_ff  <= s2_last_ff;
         s4_entry_ff <= entry_in;
      end
   end

endmodule

### src/qhs_queue.sv
// Short FIFO between the front and back ends.
module qhs_queue import qhs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type push_data,
   output logic     full,
   input  logic     pop,
   output qent_type pop_data,
   output logic     empty
);

   qent_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/qhs_back.sv
// Back end: pipelined restoring divide by the output scale, offset, saturate.
module qhs_back import qhs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     empty,
   input  qent_type pop_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   typedef struct packed {
      logic [DIVIDEND_W-1:0] rem;
      logic [QUO_BITS-1:0]   quo;
      logic                  sat;
      logic                  last;
   } div_stage_type;

   div_stage_type         st_ff   [QUO_BITS+1];
   div_stage_type         step_in [QUO_BITS];
   logic [QUO_BITS:0]     st_valid_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff, rsp_payload_in;
   logic                  advance;
   logic [SAMPLE_W+1:0]   sum_in;

   assign advance     = !(rsp_valid_ff && rsp_stall);
   assign pop         = !empty && advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
      logic [DIVIDEND_W-1:0] divisor;
      logic                  fits;
      assign divisor    = DIVIDEND_W'(cfg.out_scale) << (QUO_BITS - 1 - j);
      assign fits       = (st_ff[j].rem >= divisor);
      assign step_in[j] = '{rem:  fits ? st_ff[j].rem - divisor : st_ff[j].rem,
                            quo:  {st_ff[j].quo[QUO_BITS-2:0], fits},
                            sat:  st_ff[j].sat,
                            last: st_ff[j].last};
   end

   // add zero point and saturate
   assign sum_in = {2'b00, st_ff[QUO_BITS].quo}
                 + {{2{cfg.zero_offset[SAMPLE_W-1]}}, cfg.zero_offset};
   always_comb begin
      rsp_payload_in.last_out = st_ff[QUO_BITS].last;
      if (st_ff[QUO_BITS].sat || ($signed(sum_in) > $signed((SAMPLE_W+2)'(ACT_MAX)))) begin
         rsp_payload_in.activation = SAMPLE_W'(ACT_MAX);
      end else if ($signed(sum_in) < $signed((SAMPLE_W+2)'(ACT_MIN))) begin
         rsp_payload_in.activation = SAMPLE_W'(ACT_MIN);
      end else begin
         rsp_payload_in.activation = sum_in[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         st_valid_ff  <= {st_valid_ff[QUO_BITS-1:0], pop};
         rsp_valid_ff <= st_valid_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= '{rem: pop_data.dividend, quo: '0,
                       sat: pop_data.sat, last: pop_data.last};
         for (int j = 0; j < QUO_BITS; j++) begin
            st_ff[j+1] <= step_in[j];
         end
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

### src/quantized_hard_sigmoid_int8.sv
// Top level of the quantized int8 hard sigmoid.
//
// Streams signed 8-bit samples, one beat per cycle unless stalled, and returns one
// int8 hard sigmoid beat per sample in order, last marker copied across. Sustained
// rate is one beat per clock while rsp_stall stays low. A request beat passes through
// four front stages (dequantising multiply, offset and clamp, reciprocal divide by
// six, saturation check), a slot of the four-entry queue and ten back stages (a load
// register, an eight-step restoring divide by out_scale, one bit per stage, then
// offset and saturate into the output register). Up to 18 beats can be in flight.
// The front and back only stall each other through the queue.
// Registers (csr_index): 0 zero_offset, 1 in_scale, 2 out_scale; other indices
// are ignored. csr_ready is always high. Write registers only when the block is
// idle. An out_scale of zero gives 127.
module quantized_hard_sigmoid_int8 import qhs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   logic     push, pop, queue_full, queue_empty;
   qent_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset <= ZERO_OFFSET_RST;
         cfg_ff.in_scale    <= IN_SCALE_RST;
         cfg_ff.out_scale   <= OUT_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_OFFSET: cfg_ff.zero_offset <= csr_data[SAMPLE_W-1:0];
            CSR_IN_SCALE:    cfg_ff.in_scale    <= csr_data;
            CSR_OUT_SCALE:   cfg_ff.out_scale   <= csr_data;
            default:         ;
         endcase
      end
   end

   qhs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push        (push),
      .push_data   (push_data),
      .queue_full  (queue_full)
   );

   qhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   qhs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .empty       (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### src/qhs_checker.sv
// Port-level checks for the quantized hard sigmoid, bound to the top level.
module qhs_checker import qhs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   localparam int MAX_IN_FLIGHT = 18;

   logic [4:0] in_flight_ff, in_flight_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      case ({req_beat, rsp_beat})
         2'b10:   in_flight_in = in_flight_ff + 1'b1;
         2'b01:   in_flight_in = in_flight_ff - 1'b1;
         default: in_flight_in = in_flight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != 5'd0)
      else $error("result beat without a pending request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= 5'(MAX_IN_FLIGHT))
      else $error("more beats in flight than the pipeline holds");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff == 5'd0 |-> !req_stall)
      else $error("request stalled while the block is empty");

endmodule

bind quantized_hard_sigmoid_int8 qhs_checker u_qhs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

### tb/qhs_beat_checker.sv
// Beat checker for the quantized int8 hard sigmoid: predicts every result and compares it.
`timescale 1ns / 100ps
module qhs_beat_checker import qhs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   localparam longint SIXTH_DIV = 6;

   cfg_type regs;
   rsp_type expected_acts[$];

   function automatic rsp_type hard_sigmoid_q(input req_type beat, input cfg_type c);
      longint  centred;
      longint  level;
      longint  ratio;
      rsp_type r;
      centred = (longint'($signed(beat.sample)) - longint'($signed(c.zero_offset)))
                * longint'(c.in_scale);
      level = centred + longint'(HALF_RANGE_Q15);
      if (level < 0) level = 0;
      if (level > longint'(SIX_Q15)) level = longint'(SIX_Q15);
      level = level / SIXTH_DIV;
      // zero divisor reads as saturated high, offset not applied
      if (c.out_scale == '0) begin
         ratio = longint'(ACT_MAX);
      end else begin
         ratio = (level << Q15_SHIFT) / longint'(c.out_scale)
                 + longint'($signed(c.zero_offset));
         if (ratio > longint'(ACT_MAX)) ratio = longint'(ACT_MAX);
         if (ratio < longint'(ACT_MIN)) ratio = longint'(ACT_MIN);
      end
      r.activation = ratio[SAMPLE_W-1:0];
      r.last_out   = beat.last_in;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         regs <= '{zero_offset: ZERO_OFFSET_RST, in_scale: IN_SCALE_RST,
                   out_scale: OUT_SCALE_RST};
         expected_acts.delete();
         fail_count = 0;
         pending   <= 0;
      end else begin
         // results first: a result can never belong to a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_acts.size() == 0) begin
               $error("activation: expected none, got %0d", $signed(rsp_payload.activation));
               fail_count = fail_count + 1;
            end else begin
               want = expected_acts.pop_front();
               if (rsp_payload.activation !== want.activation) begin
                  $error("activation: expected %0d, got %0d",
                         $signed(want.activation), $signed(rsp_payload.activation));
                  fail_count = fail_count + 1;
               end
               if (rsp_payload.last_out !== want.last_out) begin
                  $error("last_out: expected %0d, got %0d", want.last_out, rsp_payload.last_out);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expected_acts.push_back(hard_sigmoid_q(req_payload, regs));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_OFFSET: regs.zero_offset <= csr_data[SAMPLE_W-1:0];
               CSR_IN_SCALE:    regs.in_scale    <= csr_data[SCALE_W-1:0];
               CSR_OUT_SCALE:   regs.out_scale   <= csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         pending <= expected_acts.size();
      end
   end

endmodule

### tb/quantized_hard_sigmoid_int8_tb.sv
// Top of the quantized int8 hard sigmoid testbench: clock, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module quantized_hard_sigmoid_int8_tb;
   import qhs_pkg::*;

   localparam int         PHASE_BEATS     = 55;
   localparam int         RANDOM_PHASES   = 8;
   localparam int         HOLD_PHASE      = 2;   // receiver holds off at the start of this one
   localparam int         PAUSE_PHASE     = 5;   // sender drains the pipe half-way through
   localparam int         HOLD_OFF_CYCLES = 200;
   localparam int         DRAIN_CYCLES    = 40;  // well past the pipeline latency
   localparam int         IDLE_LIMIT      = 2000;
   localparam logic [1:0] CSR_SPARE       = 2'd3; // no register behind this index
   localparam int         SCALE_MAX       = (1 << SCALE_W) - 1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   int   fail_count;
   int   pending;

   // Receiver-side control. hold_asks is bumped by the stimulus, hold_served by the receiver.
   int   hold_asks     = 0;
   int   hold_served   = 0;
   logic rx_quiet      = 1'b0;
   int   rx_hold_left  = 0;
   int   rx_stall_left = 0;
   int   rx_run_left   = 0;
   bit   tx_gaps_on    = 1'b1;
   int   idle_cycles   = 0;

   always #5 clock = ~clock;

   quantized_hard_sigmoid_int8 u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   qhs_beat_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Result side back-pressure. A requested hold-off wins over everything, then the
   // quiet tail, then random stall bursts mixed with runs of free flow, some of them
   // long. One assignment to rsp_stall per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_hold_left > 0 || hold_asks != hold_served) begin
         if (rx_hold_left == 0) begin
            rx_hold_left = HOLD_OFF_CYCLES;
            hold_served  = hold_served + 1;
         end
         rx_hold_left = rx_hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rx_quiet) begin
         rsp_stall <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left = rx_stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rx_run_left > 0) begin
         rx_run_left = rx_run_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 5))
            0, 1: begin
               rx_stall_left = int'($urandom_range(1, 14)) - 1;
               rsp_stall <= 1'b1;
            end
            2: begin
               rx_run_left = int'($urandom_range(40, 80)) - 1;
               rsp_stall <= 1'b0;
            end
            default: begin
               rx_run_left = int'($urandom_range(1, 20)) - 1;
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // Watchdog: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("** quantized_hard_sigmoid_int8: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type sample_beat(input int value, input bit last);
      req_type b;
      b.sample  = SAMPLE_W'(value);
      b.last_in = last;
      return b;
   endfunction

   function automatic req_type random_beat();
      req_type b;
      b.sample  = SAMPLE_W'($urandom);
      b.last_in = ($urandom_range(0, 7) == 0);
      return b;
   endfunction

   function automatic cfg_type make_cfg(input int zero, input int in_sc, input int out_sc);
      cfg_type c;
      c.zero_offset = SAMPLE_W'(zero);
      c.in_scale    = SCALE_W'(in_sc);
      c.out_scale   = SCALE_W'(out_sc);
      return c;
   endfunction

   // Mostly settings that land in the interesting part of the curve: the input scale
   // is drawn from 64 to 4096 half the time, and the output scale mostly from 1 << 20
   // up to its maximum. Extremes come up now and then.
   function automatic cfg_type random_cfg();
      cfg_type c;
      case ($urandom_range(0, 7))
         0:       c.zero_offset = SAMPLE_W'(ACT_MIN);
         1:       c.zero_offset = SAMPLE_W'(ACT_MAX);
         2, 3:    c.zero_offset = SAMPLE_W'($urandom);
         default: c.zero_offset = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      endcase
      case ($urandom_range(0, 9))
         0:       c.in_scale = '0;
         1:       c.in_scale = SCALE_W'(SCALE_MAX);
         2:       c.in_scale = SCALE_W'(1);
         3, 4:    c.in_scale = SCALE_W'($urandom_range(0, SCALE_MAX));
         default: c.in_scale = SCALE_W'($urandom_range(64, 4096));
      endcase
      case ($urandom_range(0, 9))
         0:       c.out_scale = '0;
         1:       c.out_scale = SCALE_W'(1);
         2:       c.out_scale = SCALE_W'(SCALE_MAX);
         3:       c.out_scale = SCALE_W'($urandom_range(0, SCALE_MAX));
         default: c.out_scale = SCALE_W'($urandom_range(1 << 20, SCALE_MAX));
      endcase
      return c;
   endfunction

   // One request beat. An optional idle burst first, then valid stays up until taken.
   task automatic send_sample(input req_type b);
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_beat(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all three registers back to back. The zero point rides in the low byte with
   // junk above it; the spare index gets junk that must change nothing.
   task automatic program_regs(input cfg_type c, input bit poke_spare);
      csr_beat(CSR_ZERO_OFFSET, {(CSR_DATA_W - SAMPLE_W)'($urandom), c.zero_offset});
      if (poke_spare) csr_beat(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_beat(CSR_IN_SCALE, c.in_scale);
      csr_beat(CSR_OUT_SCALE, c.out_scale);
      csr_valid <= 1'b0;
   endtask

   // Stop offering and wait for every outstanding result; every beat yields one, so an
   // empty scoreboard means the pipe is empty. The extra edge lets pending catch up.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: both ends of the sample range, the centre and the knee codes.
      send_sample(sample_beat(-128, 1'b0));
      send_sample(sample_beat(127, 1'b0));
      send_sample(sample_beat(0, 1'b1));
      send_sample(sample_beat(1, 1'b0));
      send_sample(sample_beat(-1, 1'b1));
      send_sample(sample_beat(3, 1'b0));
      send_sample(sample_beat(-3, 1'b1));

      // Widest product, positive side, with the smallest divisor: hard saturation.
      settle();
      program_regs(make_cfg(ACT_MIN, SCALE_MAX, 1), 1'b1);
      send_sample(sample_beat(-128, 1'b0));
      send_sample(sample_beat(127, 1'b0));
      send_sample(sample_beat(0, 1'b1));

      // Widest product, negative side, largest divisor.
      settle();
      program_regs(make_cfg(ACT_MAX, SCALE_MAX, SCALE_MAX), 1'b0);
      send_sample(sample_beat(-128, 1'b1));
      send_sample(sample_beat(127, 1'b0));

      // Input scale of zero: every sample lands on the midpoint.
      settle();
      program_regs(make_cfg(64, 0, 1 << 22), 1'b0);
      send_sample(sample_beat(-128, 1'b0));
      send_sample(sample_beat(127, 1'b1));

      // Output scale of zero: flagged as saturating, result pinned high.
      settle();
      program_regs(make_cfg(-5, 1000, 0), 1'b1);
      send_sample(sample_beat(-128, 1'b0));
      send_sample(sample_beat(127, 1'b1));
      send_sample(sample_beat(0, 1'b0));

      // Smallest input scale: the clamp never engages.
      settle();
      program_regs(make_cfg(0, 1, SCALE_MAX), 1'b0);
      send_sample(sample_beat(-128, 1'b1));
      send_sample(sample_beat(127, 1'b0));

      // Random phases, fresh settings each. The hold-off phase fills the pipe with the
      // sender running flat out; the pause phase drains it mid-stream; the last phase
      // runs with no idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == RANDOM_PHASES - 1) begin
            tx_gaps_on = 1'b0;
            rx_quiet  <= 1'b1;
         end
         program_regs(random_cfg(), 1'($urandom_range(0, 1)));
         if (p == HOLD_PHASE) begin
            hold_asks <= hold_asks + 1;
            tx_gaps_on = 1'b0;
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == HOLD_PHASE && n == 40) tx_gaps_on = 1'b1;
            if (p == PAUSE_PHASE && n == PHASE_BEATS / 2) settle();
            send_sample(random_beat());
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** quantized_hard_sigmoid_int8: PASSED **");
      end else begin
         $display("** quantized_hard_sigmoid_int8: FAILED **");
      end
      $finish;
   end

endmodule
